/* src/dup_pkg.sv */
package dup_pkg;

    // Packet size in bytes; the word limit follows from it
    localparam int PACKET_BYTES = 1024;
    localparam int LIMIT_PLAIN  = PACKET_BYTES / 4;
    localparam int LIMIT_TS     = PACKET_BYTES / 8;
    localparam int CNT_W        = $clog2(LIMIT_PLAIN + 2);

    // Field widths
    localparam int COORD_W    = 15;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Coordinate divider: quotient bits resolved per cycle
    localparam int DIV_STEPS = 5;
    localparam int DIV_ITERS = COORD_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATE  = 3'd0,
        CFG_WIDTH   = 3'd1,
        CFG_HEIGHT  = 3'd2,
        CFG_SCALE_X = 3'd3,
        CFG_SCALE_Y = 3'd4,
        CFG_TS_EN   = 3'd5,
        CFG_DUAL    = 3'd6
    } t_cfg_index;

    // One encoded event waiting to be sent
    typedef struct packed {
        logic [WORD_W-1:0] primary;
        logic [WORD_W-1:0] ts_word;
        logic [WORD_W-1:0] secondary;
        logic              ts_en;
        logic              dual;
        logic              close;
    } t_entry;

    typedef enum logic {
        FS_IDLE,
        FS_DIV
    } t_front_state;

    typedef enum logic [1:0] {
        BS_PRIMARY,
        BS_TIME,
        BS_SECONDARY
    } t_back_state;

endpackage

/* src/dup_divider.sv */
module dup_divider import dup_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [COORD_W-1:0] i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_quo;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_div;

    logic [COORD_W-1:0]   w_quo;
    logic [COORD_W-1:0]   w_rem;
    logic [COORD_W:0]     w_ext;

    // Restoring division, several quotient bits per cycle
    always_comb begin
        w_quo = r_quo;
        w_rem = r_rem;
        w_ext = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_ext = {w_rem, w_quo[COORD_W-1]};
            w_quo = {w_quo[COORD_W-2:0], 1'b0};
            if (w_ext >= {1'b0, r_div}) begin
                w_rem    = COORD_W'(w_ext - {1'b0, r_div});
                w_quo[0] = 1'b1;
            end else begin
                w_rem = w_ext[COORD_W-1:0];
            end
        end
    end

    // Sequence the iterations; a zero divisor passes the dividend through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_divisor != '0);
            r_done <= (i_divisor == '0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= w_quo;
            r_rem <= w_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

endmodule

/* src/dup_front.sv */
module dup_front import dup_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_W-1:0]    i_pos_x,
    input  logic [COORD_W-1:0]    i_pos_y,
    input  logic                  i_polarity,
    input  logic [WORD_W-1:0]     i_event_time,
    input  logic                  i_end_of_stream,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_entry                o_entry
);

    t_front_state         r_state;
    t_front_state         n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     w_sum;
    logic                 w_close;

    logic                 r_rotate;
    logic [COORD_W-1:0]   r_width;
    logic [COORD_W-1:0]   r_height;
    logic [COORD_W-1:0]   r_scale_x;
    logic [COORD_W-1:0]   r_scale_y;
    logic                 r_ts_en;
    logic                 r_dual;

    logic                 r_pol;
    logic [WORD_W-1:0]    r_time;
    logic                 r_eos;

    logic                 w_accept;
    logic [COORD_W-1:0]   w_rot_x;
    logic [COORD_W-1:0]   w_rot_y;
    logic                 w_x_done;
    logic                 w_y_done;
    logic [COORD_W-1:0]   w_qx;
    logic [COORD_W-1:0]   w_qy;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate  <= 1'b0;
            r_width   <= '0;
            r_height  <= '0;
            r_scale_x <= '0;
            r_scale_y <= '0;
            r_ts_en   <= 1'b0;
            r_dual    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROTATE:  r_rotate  <= i_cfg_data[0];
                CFG_WIDTH:   r_width   <= i_cfg_data;
                CFG_HEIGHT:  r_height  <= i_cfg_data;
                CFG_SCALE_X: r_scale_x <= i_cfg_data;
                CFG_SCALE_Y: r_scale_y <= i_cfg_data;
                CFG_TS_EN:   r_ts_en   <= i_cfg_data[0];
                CFG_DUAL:    r_dual    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Mirror coordinates when rotation is on, saturating at zero
    always_comb begin
        w_rot_x = i_pos_x;
        w_rot_y = i_pos_y;
        if (r_rotate) begin
            w_rot_x = (i_pos_x > r_width)  ? '0 : r_width - i_pos_x;
            w_rot_y = (i_pos_y > r_height) ? '0 : r_height - i_pos_y;
        end
    end

    dup_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_rot_x),
        .i_divisor  (r_scale_x),
        .o_done     (w_x_done),
        .o_quotient (w_qx)
    );

    dup_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_rot_y),
        .i_divisor  (r_scale_y),
        .o_done     (w_y_done),
        .o_quotient (w_qy)
    );

    // Hold the rest of the event
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pol  <= i_polarity;
            r_time <= i_event_time;
            r_eos  <= i_end_of_stream;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (w_accept) n_state = FS_DIV;
            FS_DIV:  if (w_x_done && w_y_done && !i_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            FS_IDLE: o_in_ready = 1'b1;
            FS_DIV:  o_push     = w_x_done && w_y_done && !i_full;
            default: ;
        endcase
    end

    // Count words in the open packet and decide the close
    always_comb begin
        w_sum   = r_cnt + (r_ts_en ? CNT_W'(2) : CNT_W'(1));
        w_close = (r_ts_en ? (w_sum >= CNT_W'(LIMIT_TS)) : (w_sum >= CNT_W'(LIMIT_PLAIN)))
                  || r_eos;
        n_cnt   = w_close ? '0 : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_push) r_cnt <= n_cnt;
        end
    end

    // Encode the words of this event
    always_comb begin
        o_entry.primary   = {~r_ts_en, w_qx, r_pol, w_qy};
        o_entry.ts_word   = r_time;
        o_entry.secondary = {1'b1, w_qx[COORD_W-2:0], r_pol, 1'b0, w_qy};
        o_entry.ts_en     = r_ts_en;
        o_entry.dual      = r_dual;
        o_entry.close     = w_close;
    end

    a_cnt_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(LIMIT_PLAIN))
        else $error("word counter reached the packet limit");

endmodule

/* src/dup_queue.sv */
module dup_queue import dup_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

/* src/dup_back.sv */
module dup_back import dup_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_entry            i_entry,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_stream_select,
    output logic [WORD_W-1:0] o_packet_word,
    output logic              o_packet_end,
    output logic              o_item_last
);

    t_back_state       r_state;
    t_back_state       n_state;
    logic              r_out_valid;
    logic              r_sel;
    logic [WORD_W-1:0] r_word;
    logic              r_pend;
    logic              r_last;

    logic              w_load;
    logic              w_sel;
    logic [WORD_W-1:0] w_word;
    logic              w_pend;
    logic              w_last;

    assign w_load = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_load && w_last;

    // Select the word for the current step
    always_comb begin
        w_sel  = 1'b0;
        w_word = i_entry.primary;
        w_pend = 1'b0;
        w_last = 1'b1;
        case (r_state)
            BS_PRIMARY: begin
                w_pend = !i_entry.ts_en && i_entry.close;
                w_last = !i_entry.ts_en && !i_entry.dual;
            end
            BS_TIME: begin
                w_word = i_entry.ts_word;
                w_pend = i_entry.close;
                w_last = !i_entry.dual;
            end
            BS_SECONDARY: begin
                w_sel  = 1'b1;
                w_word = i_entry.secondary;
                w_pend = i_entry.close;
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (w_load) begin
            if (w_last) begin
                n_state = BS_PRIMARY;
            end else begin
                case (r_state)
                    BS_PRIMARY: n_state = i_entry.ts_en ? BS_TIME : BS_SECONDARY;
                    BS_TIME:    n_state = BS_SECONDARY;
                    default:    n_state = BS_PRIMARY;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_PRIMARY;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sel  <= w_sel;
            r_word <= w_word;
            r_pend <= w_pend;
            r_last <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stream_select = r_sel;
    assign o_packet_word   = r_word;
    assign o_packet_end    = r_pend;
    assign o_item_last     = r_last;

    a_secondary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sel) |-> r_last)
        else $error("secondary word not last of its event");

    a_mid_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_PRIMARY) |-> i_valid)
        else $error("mid-event step with empty queue");

endmodule

/* src/dvs_event_udp_packer.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_ready | pos_x, pos_y, polarity, event_time, eos
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// out     | output    | o_out_valid/i_out_ready | stream_select, packet_word, end, last
//
// An event passes the front in steps: accept, the iterations of the two coordinate
// dividers (5 quotient bits per cycle), then the push into the request queue, which
// waits while the queue is full; a zero scale divisor skips its divider's iterations.
// The back sends 1 to 3 words per event via an output register, one per cycle when ready.
// The front takes a new event only after it has pushed the previous one.
// Reset is synchronous, active low; it clears all configuration and the word counter.
// A stalled output fills the two-entry queue and then holds the input off.
module dvs_event_udp_packer import dup_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_W-1:0]    i_pos_x,
    input  logic [COORD_W-1:0]    i_pos_y,
    input  logic                  i_polarity,
    input  logic [WORD_W-1:0]     i_event_time,
    input  logic                  i_end_of_stream,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_stream_select,
    output logic [WORD_W-1:0]     o_packet_word,
    output logic                  o_packet_end,
    output logic                  o_item_last
);

    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;
    t_entry w_push_entry;
    t_entry w_head_entry;

    dup_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_polarity      (i_polarity),
        .i_event_time    (i_event_time),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    dup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry),
        .i_pop   (w_pop)
    );

    dup_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_entry         (w_head_entry),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stream_select (o_stream_select),
        .o_packet_word   (o_packet_word),
        .o_packet_end    (o_packet_end),
        .o_item_last     (o_item_last)
    );

endmodule

/* tb/dvs_event_udp_packer_tb.sv */
`timescale 1ns / 1ps

module dvs_event_udp_packer_tb import dup_pkg::*; ();

    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_GAP       = 8;
    localparam int LONG_HOLD     = 80;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               pol;
        logic [WORD_W-1:0]  stamp;
        logic               eos;
    } t_dvs_sample;

    typedef struct packed {
        logic              sel;
        logic [WORD_W-1:0] word;
        logic              pend;
        logic              last;
    } t_packet_word;

    // Track the packer's settings and open-packet count, queue predicted words
    class packet_word_board;
        logic               rot;
        logic [COORD_W-1:0] sensor_w;
        logic [COORD_W-1:0] sensor_h;
        logic [COORD_W-1:0] div_x;
        logic [COORD_W-1:0] div_y;
        logic               ts_on;
        logic               dual_on;
        int                 words_open;
        t_packet_word       expected_words[$];
        int                 errors;
        int                 samples_seen;
        int                 words_checked;
        int                 packets_closed;

        function new();
            rot = 0; sensor_w = '0; sensor_h = '0; div_x = '0; div_y = '0;
            ts_on = 0; dual_on = 0; words_open = 0;
            errors = 0; samples_seen = 0; words_checked = 0; packets_closed = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROTATE:  rot = data[0];
                CFG_WIDTH:   sensor_w = data;
                CFG_HEIGHT:  sensor_h = data;
                CFG_SCALE_X: div_x = data;
                CFG_SCALE_Y: div_y = data;
                CFG_TS_EN:   ts_on = data[0];
                CFG_DUAL:    dual_on = data[0];
                default: ;
            endcase
        endfunction

        // Encode one accepted request into the words it must produce
        function void note_sample(t_dvs_sample s);
            logic [COORD_W-1:0] x;
            logic [COORD_W-1:0] y;
            logic [WORD_W-1:0]  primary;
            logic [WORD_W-1:0]  secondary;
            logic               close;
            int                 limit;
            t_packet_word       w;
            x = s.x;
            y = s.y;
            // mirror, clamping at zero when past the sensor edge
            if (rot) begin
                x = (x > sensor_w) ? '0 : sensor_w - x;
                y = (y > sensor_h) ? '0 : sensor_h - y;
            end
            if (div_x != 0) x = x / div_x;
            if (div_y != 0) y = y / div_y;
            // untimed primary words carry a marker in the top bit
            primary   = {~ts_on, x, s.pol, y};
            secondary = {1'b1, x[COORD_W-2:0], s.pol, 1'b0, y};
            words_open += ts_on ? 2 : 1;
            limit = ts_on ? LIMIT_TS : LIMIT_PLAIN;
            close = (words_open >= limit) || s.eos;
            if (close) begin
                words_open = 0;
                packets_closed++;
            end
            if (ts_on) begin
                w = '{sel: 1'b0, word: primary, pend: 1'b0, last: 1'b0};
                expected_words.push_back(w);
                w = '{sel: 1'b0, word: s.stamp, pend: close, last: ~dual_on};
                expected_words.push_back(w);
            end else begin
                w = '{sel: 1'b0, word: primary, pend: close, last: ~dual_on};
                expected_words.push_back(w);
            end
            if (dual_on) begin
                w = '{sel: 1'b1, word: secondary, pend: close, last: 1'b1};
                expected_words.push_back(w);
            end
            samples_seen++;
        endfunction

        function void check_word(t_packet_word got);
            t_packet_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: stream %0d word %h end %0d last %0d",
                       got.sel, got.word, got.pend, got.last);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.sel !== want.sel) begin
                $error("stream_select: expected %0d, got %0d", want.sel, got.sel);
                errors++;
            end
            if (got.word !== want.word) begin
                $error("packet_word: expected %h, got %h", want.word, got.word);
                errors++;
            end
            if (got.pend !== want.pend) begin
                $error("packet_end: expected %0d, got %0d", want.pend, got.pend);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("item_last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [COORD_W-1:0]    i_pos_x;
    logic [COORD_W-1:0]    i_pos_y;
    logic                  i_polarity;
    logic [WORD_W-1:0]     i_event_time;
    logic                  i_end_of_stream;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_stream_select;
    logic [WORD_W-1:0]     o_packet_word;
    logic                  o_packet_end;
    logic                  o_item_last;

    packet_word_board board;
    int               hold_request = 0;
    bit               tx_burst = 0;
    int               setups_applied = 0;

    dvs_event_udp_packer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_polarity      (i_polarity),
        .i_event_time    (i_event_time),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stream_select (o_stream_select),
        .o_packet_word   (o_packet_word),
        .o_packet_end    (o_packet_end),
        .o_item_last     (o_item_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request; valid is left high so a back-to-back request follows cleanly
    task automatic send_sample(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic pol, input logic [WORD_W-1:0] stamp,
                               input logic eos);
        int          gap;
        t_dvs_sample s;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        s = '{x: x, y: y, pol: pol, stamp: stamp, eos: eos};
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pos_x         <= x;
        i_pos_y         <= y;
        i_polarity      <= pol;
        i_event_time    <= stamp;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s);
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    // Program all registers while the packer is idle
    task automatic apply_setup(input logic rot, input logic [COORD_W-1:0] w,
                               input logic [COORD_W-1:0] h, input logic [COORD_W-1:0] dx,
                               input logic [COORD_W-1:0] dy, input logic ts,
                               input logic dual);
        drain();
        write_reg(CFG_ROTATE,  CFG_DATA_W'(rot));
        write_reg(CFG_WIDTH,   w);
        write_reg(CFG_HEIGHT,  h);
        write_reg(CFG_SCALE_X, dx);
        write_reg(CFG_SCALE_Y, dy);
        write_reg(CFG_TS_EN,   CFG_DATA_W'(ts));
        write_reg(CFG_DUAL,    CFG_DATA_W'(dual));
        i_cfg_valid <= 1'b0;
        setups_applied++;
    endtask

    // Accept output words with random stalls, runs of no stall, and a long hold on request
    initial begin
        int           stall;
        bit           rx_fast;
        t_packet_word got;
        rx_fast = 0;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = '{sel: o_stream_select, word: o_packet_word, pend: o_packet_end,
                    last: o_item_last};
            board.check_word(got);
        end
    end

    // Stimulus
    initial begin
        int                 phase_len;
        int                 eos_odds;
        logic               ts;
        logic [COORD_W-1:0] sw;
        logic [COORD_W-1:0] sh;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        board = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_pos_x         <= '0;
        i_pos_y         <= '0;
        i_polarity      <= 1'b0;
        i_event_time    <= '0;
        i_end_of_stream <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_ROTATE;
        i_cfg_data      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: plain primary words, field extremes, end of stream
        send_sample(15'h0000, 15'h0000, 1'b0, 32'h0000_0000, 1'b0);
        send_sample(15'h7FFF, 15'h7FFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_sample(15'h1234, 15'h2345, 1'b1, 32'h55AA_55AA, 1'b1);

        // Timestamps and secondary stream together
        apply_setup(1'b0, '0, '0, '0, '0, 1'b1, 1'b1);
        send_sample(15'h7FFF, 15'h0000, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_sample(15'h0000, 15'h7FFF, 1'b0, 32'h0000_0000, 1'b1);

        // Rotation: underflow clamps to zero, exact edge, origin
        apply_setup(1'b1, 15'd100, 15'd50, '0, '0, 1'b0, 1'b1);
        send_sample(15'd150, 15'd20, 1'b0, 32'hA5A5_A5A5, 1'b0);
        send_sample(15'd100, 15'd51, 1'b1, 32'h5A5A_5A5A, 1'b0);
        send_sample(15'd0, 15'd0, 1'b0, 32'h0F0F_0F0F, 1'b1);

        // Full-size sensor with extreme divisors
        apply_setup(1'b1, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd1, 1'b0, 1'b1);
        send_sample(15'd0, 15'd0, 1'b1, 32'h1234_5678, 1'b0);
        send_sample(15'h7FFF, 15'h7FFF, 1'b0, 32'h8765_4321, 1'b1);

        // Plain scaling, timestamps only
        apply_setup(1'b0, '0, '0, 15'd3, 15'd7, 1'b1, 1'b0);
        send_sample(15'h7FFF, 15'd100, 1'b1, 32'hDEAD_BEEF, 1'b0);
        send_sample(15'd2, 15'd6, 1'b0, 32'h0000_0001, 1'b1);

        // Random phases; the long timestamp phase runs past the packet limit
        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 2))
                0: sw = '0;
                1: sw = 15'h7FFF;
                default: sw = COORD_W'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 2))
                0: sh = '0;
                1: sh = 15'h7FFF;
                default: sh = COORD_W'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 4))
                0: dx = '0;
                1: dx = 15'd1;
                2: dx = 15'h7FFF;
                3: dx = COORD_W'($urandom_range(2, 20));
                default: dx = COORD_W'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 4))
                0: dy = '0;
                1: dy = 15'd1;
                2: dy = 15'h7FFF;
                3: dy = COORD_W'($urandom_range(2, 20));
                default: dy = COORD_W'($urandom_range(0, 32767));
            endcase
            ts = (p == 3) ? 1'b1 : 1'($urandom_range(0, 1));
            apply_setup(1'($urandom_range(0, 1)), sw, sh, dx, dy, ts,
                        1'($urandom_range(0, 1)));
            phase_len = (p == 3) ? 70 : 12;
            eos_odds  = (p == 3 || p == 2) ? 0 : 24;
            tx_burst  = (p == 3) ? 1'b1 : 1'($urandom_range(0, 1));
            for (int i = 0; i < phase_len; i++) begin
                if (p == 3 && i == 10) hold_request = LONG_HOLD;
                if (p == 3 && i == 40) tx_burst = 0;
                send_sample(COORD_W'($urandom_range(0, 32767)),
                            COORD_W'($urandom_range(0, 32767)),
                            1'($urandom_range(0, 1)), $urandom,
                            (eos_odds > 0) && ($urandom_range(0, eos_odds - 1) == 0));
            end
        end

        drain();
        $display("Covered %0d events and %0d output words over %0d register setups.",
                 board.samples_seen, board.words_checked, setups_applied + 1);
        $display("Predicted %0d packet closes, by end of stream and by word limit.",
                 board.packets_closed);
        if (board.errors == 0) begin
            $display("dvs_event_udp_packer verification clean");
        end else begin
            $display("dvs_event_udp_packer verification failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("dvs_event_udp_packer verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/dup_pkg.sv
src/dup_divider.sv
src/dup_front.sv
src/dup_queue.sv
src/dup_back.sv
src/dvs_event_udp_packer.sv
tb/dvs_event_udp_packer_tb.sv
